// ===== hdl/slwa_pkg.sv =====
// ----------------------------------------------------------------------------
// slwa_pkg: shared types and constants of the sorted key leaf
// Capacity, field widths, operation codes and the accounting request that
// passes from the leaf front end to the counter unit.
// ----------------------------------------------------------------------------
package slwa_pkg;

    localparam int CAPACITY     = 32;
    localparam int KEY_W        = 64;
    localparam int CTR_W        = 48;
    localparam int ENTRY_W      = 6;
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int LOG_WORDS    = 4;
    localparam int LOG_FLUSHES  = 2;
    localparam int LOG_FENCES   = 2;
    // worst case: every entry shifts, plus the new key, plus the log record
    localparam int COST_W       = $clog2(CAPACITY + 1 + LOG_WORDS + 1);

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [CTR_W-1:0]   ctr_t;
    typedef logic [CTR_W:0]     ctr_ext_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [COST_W-1:0]  cost_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    // operation codes carried on s_tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // one counter update for an accepted insert
    typedef struct packed {
        logic  add;
        logic  log_rec;
        cost_t words;
    } acct_req_t;

    // saturating add onto a counter
    function automatic ctr_t sat_add(ctr_t acc, cost_t inc);
        ctr_ext_t sum;
        sum = {1'b0, acc} + ctr_ext_t'(inc);
        if (sum[CTR_W]) begin
            return {CTR_W{1'b1}};
        end
        return sum[CTR_W-1:0];
    endfunction

endpackage

// ===== hdl/slwa_cell.sv =====
// ----------------------------------------------------------------------------
// slwa_cell: one slot of the sorted key row
// Holds one key, compares it with the item key and on an insert keeps its
// key, takes the new key or takes its left neighbor's key.
// ----------------------------------------------------------------------------
module slwa_cell (
    input  logic          aclk,
    input  slwa_pkg::key_t item_key,
    input  slwa_pkg::key_t left_key,
    input  logic          left_stay,
    input  logic          occupied,
    input  logic          shift_en,
    output slwa_pkg::key_t key_q,
    output logic          stay,
    output logic          boundary,
    output logic          hit
);

    slwa_pkg::key_t key_reg;
    slwa_pkg::key_t key_next;

    // compare the held key against the item key
    assign stay     = occupied && (key_reg < item_key);
    assign boundary = left_stay && !stay;
    assign hit      = occupied && (key_reg == item_key);
    assign key_q    = key_reg;

    // keep, insert here, or shift in from the left
    always_comb begin
        if (stay) begin
            key_next = key_reg;
        end else if (left_stay) begin
            key_next = item_key;
        end else begin
            key_next = left_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            key_reg <= key_next;
        end
    end

endmodule

// ===== hdl/slwa_acct.sv =====
// ----------------------------------------------------------------------------
// slwa_acct: saturating write, flush and fence counters
// Adds the cost of each accepted insert, with the log record cost in
// logged mode.
// ----------------------------------------------------------------------------
module slwa_acct (
    input  logic                aclk,
    input  logic                aresetn,
    input  slwa_pkg::acct_req_t req,
    output slwa_pkg::ctr_t      word_writes,
    output slwa_pkg::ctr_t      flushes,
    output slwa_pkg::ctr_t      fences
);

    slwa_pkg::ctr_t writes_reg, writes_next;
    slwa_pkg::ctr_t flush_reg, flush_next;
    slwa_pkg::ctr_t fence_reg, fence_next;

    // add the cost of one insert
    always_comb begin
        writes_next = writes_reg;
        flush_next  = flush_reg;
        fence_next  = fence_reg;
        if (req.add) begin
            writes_next = slwa_pkg::sat_add(writes_reg, req.words);
            if (req.log_rec) begin
                flush_next = slwa_pkg::sat_add(flush_reg,
                    slwa_pkg::cost_t'(slwa_pkg::LOG_FLUSHES));
                fence_next = slwa_pkg::sat_add(fence_reg,
                    slwa_pkg::cost_t'(slwa_pkg::LOG_FENCES));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            writes_reg <= '0;
            flush_reg  <= '0;
            fence_reg  <= '0;
        end else begin
            writes_reg <= writes_next;
            flush_reg  <= flush_next;
            fence_reg  <= fence_next;
        end
    end

    assign word_writes = writes_reg;
    assign flushes     = flush_reg;
    assign fences      = fence_reg;

endmodule

// ===== hdl/sorted_leaf_with_write_accounting_top.sv =====
// ----------------------------------------------------------------------------
// sorted_leaf_with_write_accounting_top: sorted key leaf with cost counters
// Row of compare-and-shift cells holding the keys, a pending stage and a
// result register.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: s_tdata carries the 64-bit key, s_tuser the operation
//   (insert or search). m_ channel: one result item per input item with
//   found, accepted, entry count and the three counter totals.
//   cfg_we / cfg_wdata write the logging mode; write it only while idle.
// Path: an accepted item waits in the pending stage, and m_tvalid rises
//   when the item moves on into the result register.
// Throughput: one item per cycle while results are taken. The cell row
//   resolves the insert position, the search hit and the shift in the accept
//   cycle; the counters update with the result register, from a registered cost.
// Reset: aresetn low empties the leaf (fill count zero), clears the
//   counters and the logging mode. Key cells keep stale data; slots at or
//   above the fill count are never read.
// Stall: while m_tready is low the result holds; one further item is taken
//   into the pending stage, after which s_tready stays low until the
//   result is taken.
// ----------------------------------------------------------------------------
module sorted_leaf_with_write_accounting_top (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_we,
    input  logic         cfg_wdata,     // logging_enabled
    // input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,       // [63:0] key
    input  logic         s_tuser,       // [0] operation
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata        // [0] found, [1] accepted,
                                        // [7:2] entry_count,
                                        // [55:8] word_writes,
                                        // [103:56] flushes,
                                        // [151:104] fences
);

    localparam int CAP = slwa_pkg::CAPACITY;

    logic           logging_reg;
    slwa_pkg::cnt_t fill_reg, fill_next;

    logic           pend_reg, pend_next;
    logic           pend_found_reg;
    logic           pend_acc_reg;
    slwa_pkg::entry_t pend_count_reg;
    slwa_pkg::cost_t  pend_cost_reg;
    logic           pend_log_reg;

    logic           m_valid_reg, m_valid_next;
    logic           out_found_reg;
    logic           out_acc_reg;
    slwa_pkg::entry_t out_count_reg;

    logic           a_fire, b_fire, ins_ok;
    slwa_pkg::key_t cell_key [CAP];
    logic [CAP-1:0] cell_stay, cell_boundary, cell_hit;
    slwa_pkg::idx_t ins_pos;
    logic           found;
    slwa_pkg::cnt_t shift_cnt;
    slwa_pkg::cost_t ins_cost;
    logic [slwa_pkg::CNT_W+slwa_pkg::ENTRY_W-1:0] count_ext;

    slwa_pkg::acct_req_t acct_req;
    slwa_pkg::ctr_t      word_writes, flushes, fences;

    // handshake
    assign b_fire   = pend_reg && (!m_valid_reg || m_tready);
    assign s_tready = !pend_reg || b_fire;
    assign a_fire   = s_tvalid && s_tready;
    assign ins_ok   = a_fire && (s_tuser == slwa_pkg::OP_INSERT) &&
                      (fill_reg < slwa_pkg::cnt_t'(CAP));

    // row of compare-and-shift cells
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        slwa_cell u_cell (
            .aclk      (aclk),
            .item_key  (s_tdata),
            .left_key  ((i == 0) ? s_tdata : cell_key[(i == 0) ? 0 : i - 1]),
            .left_stay ((i == 0) ? 1'b1 : cell_stay[(i == 0) ? 0 : i - 1]),
            .occupied  (slwa_pkg::cnt_t'(i) < fill_reg),
            .shift_en  (ins_ok),
            .key_q     (cell_key[i]),
            .stay      (cell_stay[i]),
            .boundary  (cell_boundary[i]),
            .hit       (cell_hit[i])
        );
    end

    // encode the one-hot insert boundary into a slot index
    always_comb begin
        ins_pos = '0;
        for (int i = 0; i < CAP; i++) begin
            if (cell_boundary[i]) begin
                ins_pos = ins_pos | slwa_pkg::idx_t'(i);
            end
        end
    end

    assign found     = |cell_hit;
    assign shift_cnt = fill_reg - slwa_pkg::cnt_t'(ins_pos);
    assign ins_cost  = slwa_pkg::cost_t'(shift_cnt) + slwa_pkg::cost_t'(1) +
                       (logging_reg ? slwa_pkg::cost_t'(slwa_pkg::LOG_WORDS)
                                    : slwa_pkg::cost_t'(0));
    assign fill_next = ins_ok ? fill_reg + slwa_pkg::cnt_t'(1) : fill_reg;
    assign count_ext = {{slwa_pkg::ENTRY_W{1'b0}}, fill_next};

    // pending stage and result valid
    always_comb begin
        pend_next = pend_reg;
        if (a_fire) begin
            pend_next = 1'b1;
        end else if (b_fire) begin
            pend_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (b_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            logging_reg <= 1'b0;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                logging_reg <= cfg_wdata;
            end
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // capture the item's outcome
    always_ff @(posedge aclk) begin
        if (a_fire) begin
            pend_found_reg <= (s_tuser == slwa_pkg::OP_SEARCH) && found;
            pend_acc_reg   <= ins_ok;
            pend_count_reg <= count_ext[slwa_pkg::ENTRY_W-1:0];
            pend_cost_reg  <= ins_cost;
            pend_log_reg   <= logging_reg;
        end
        if (b_fire) begin
            out_found_reg <= pend_found_reg;
            out_acc_reg   <= pend_acc_reg;
            out_count_reg <= pend_count_reg;
        end
    end

    // counters advance with the result register
    assign acct_req.add     = b_fire && pend_acc_reg;
    assign acct_req.log_rec = pend_log_reg;
    assign acct_req.words   = pend_cost_reg;

    slwa_acct u_acct (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (acct_req),
        .word_writes (word_writes),
        .flushes     (flushes),
        .fences      (fences)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {fences, flushes, word_writes, out_count_reg,
                       out_acc_reg, out_found_reg};

endmodule

// ===== hdl/slwa_checker.sv =====
// ----------------------------------------------------------------------------
// slwa_checker: port-level checks of the sorted key leaf
// Watches the result channel for stability, counter monotonicity and
// consistency between the result fields.
// ----------------------------------------------------------------------------
module slwa_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata
);

    // hold a stalled result item
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result item changed");

    // an item is never both a hit and a stored insert
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("found and accepted both set");

    // flushes and fences always advance together
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[103:56] == m_tdata[151:104]))
        else $error("flush and fence totals differ");

    // word writes never drop
    a_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && m_tvalid && $past(m_tvalid)) |->
            (m_tdata[55:8] >= $past(m_tdata[55:8])))
        else $error("word write total decreased");

endmodule

bind sorted_leaf_with_write_accounting_top slwa_checker u_slwa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted key leaf
// Drives insert and search items on the s_ channel under random idling on
// both sides, keeps its own copy of the leaf and of the three cost counters,
// and compares every result item field by field in arrival order. A short
// table of directed items comes first, then random phases that set the
// logging mode to a random value between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1030;
    localparam int DRAIN_CYCLES = 8;

    // result item as it travels on m_tdata, lowest field last
    typedef struct packed {
        slwa_pkg::ctr_t   fences;
        slwa_pkg::ctr_t   flushes;
        slwa_pkg::ctr_t   word_writes;
        slwa_pkg::entry_t entry_count;
        logic             accepted;
        logic             found;
    } leaf_result_t;

    // one directed item, with an optional mode change before it
    typedef struct {
        logic           op;
        slwa_pkg::key_t key;
        logic           set_log;
        logic           log_val;
        logic           has_want;
        leaf_result_t   want;
    } probe_row_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [151:0] m_tdata;

    // leaf copy and counter copy
    slwa_pkg::key_t leaf_keys [slwa_pkg::CAPACITY];
    int             leaf_fill;
    slwa_pkg::ctr_t writes_total;
    slwa_pkg::ctr_t flushes_total;
    slwa_pkg::ctr_t fences_total;
    logic           log_mode;

    leaf_result_t pending_results [$];
    probe_row_t   probe_rows [$];
    leaf_result_t got_result;
    leaf_result_t want_result;
    int unsigned  mismatch_count;
    int unsigned  cycle_count;
    bit           gaps_on;

    sorted_leaf_with_write_accounting_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // add to a counter, stick at all ones
    function automatic slwa_pkg::ctr_t ctr_bump(slwa_pkg::ctr_t acc, int unsigned inc);
        logic [slwa_pkg::CTR_W:0] sum;
        sum = {1'b0, acc} + (slwa_pkg::CTR_W + 1)'(inc);
        if (sum[slwa_pkg::CTR_W]) begin
            return {slwa_pkg::CTR_W{1'b1}};
        end
        return sum[slwa_pkg::CTR_W-1:0];
    endfunction

    // apply one item to the leaf copy and return the result it must give
    function automatic leaf_result_t predict_leaf(logic op, slwa_pkg::key_t key);
        leaf_result_t r;
        int           slot;
        int unsigned  cost;
        r = '0;
        if (op == slwa_pkg::OP_INSERT) begin
            if (leaf_fill < slwa_pkg::CAPACITY) begin
                slot = 0;
                while (slot < leaf_fill && leaf_keys[slot] < key) begin
                    slot++;
                end
                for (int i = leaf_fill; i > slot; i--) begin
                    leaf_keys[i] = leaf_keys[i-1];
                end
                leaf_keys[slot] = key;
                cost = unsigned'(leaf_fill - slot + 1);
                if (log_mode) begin
                    cost += unsigned'(slwa_pkg::LOG_WORDS);
                    flushes_total = ctr_bump(flushes_total,
                                             unsigned'(slwa_pkg::LOG_FLUSHES));
                    fences_total  = ctr_bump(fences_total,
                                             unsigned'(slwa_pkg::LOG_FENCES));
                end
                writes_total = ctr_bump(writes_total, cost);
                leaf_fill++;
                r.accepted = 1'b1;
            end
        end else begin
            for (int i = 0; i < leaf_fill; i++) begin
                if (leaf_keys[i] == key) begin
                    r.found = 1'b1;
                end
            end
        end
        r.entry_count = slwa_pkg::entry_t'(leaf_fill);
        r.word_writes = writes_total;
        r.flushes     = flushes_total;
        r.fences      = fences_total;
        return r;
    endfunction

    function automatic leaf_result_t make_result(logic found, logic accepted,
                                                 int unsigned count,
                                                 slwa_pkg::ctr_t writes,
                                                 slwa_pkg::ctr_t flushes,
                                                 slwa_pkg::ctr_t fences);
        leaf_result_t r;
        r.found       = found;
        r.accepted    = accepted;
        r.entry_count = slwa_pkg::entry_t'(count);
        r.word_writes = writes;
        r.flushes     = flushes;
        r.fences      = fences;
        return r;
    endfunction

    function automatic void add_probe(logic op, slwa_pkg::key_t key, logic set_log,
                                      logic log_val, logic has_want, leaf_result_t want);
        probe_row_t row;
        row.op       = op;
        row.key      = key;
        row.set_log  = set_log;
        row.log_val  = log_val;
        row.has_want = has_want;
        row.want     = want;
        probe_rows.push_back(row);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // offer one item, idling now and then, and record what it must produce
    task automatic send_item(input logic op, input slwa_pkg::key_t key,
                             input logic has_want, input leaf_result_t want);
        leaf_result_t predicted;
        while (gaps_on && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_leaf(op, key);
        pending_results.push_back(has_want ? want : predicted);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_log(input logic mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        log_mode  = mode;
    endtask

    // random key for an insert: mostly fresh, some extremes and repeats
    function automatic slwa_pkg::key_t pick_insert_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            return '0;
        end else if (roll < 20) begin
            return '1;
        end else if (roll < 40 && leaf_fill > 0) begin
            return leaf_keys[$urandom_range(leaf_fill - 1)];
        end
        return {$urandom, $urandom};
    endfunction

    // random key for a search: held keys, their neighbors, or anything
    function automatic slwa_pkg::key_t pick_search_key();
        int unsigned    roll;
        slwa_pkg::key_t held;
        roll = $urandom_range(99);
        if (leaf_fill == 0 || roll >= 70) begin
            return {$urandom, $urandom};
        end
        held = leaf_keys[$urandom_range(leaf_fill - 1)];
        if (roll < 50) begin
            return held;
        end else if (roll < 60) begin
            return held + slwa_pkg::key_t'(1);
        end
        return held - slwa_pkg::key_t'(1);
    endfunction

    // receiver idling
    always @(posedge aclk) begin
        m_tready <= gaps_on ? ($urandom_range(99) >= 10) : 1'b1;
    end

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no expectation waiting: %h", m_tdata);
                mismatch_count++;
            end else begin
                want_result = pending_results.pop_front();
                got_result  = leaf_result_t'(m_tdata);
                check_field("found", 64'(want_result.found), 64'(got_result.found));
                check_field("accepted", 64'(want_result.accepted),
                            64'(got_result.accepted));
                check_field("entry_count", 64'(want_result.entry_count),
                            64'(got_result.entry_count));
                check_field("word_writes", 64'(want_result.word_writes),
                            64'(got_result.word_writes));
                check_field("flushes", 64'(want_result.flushes),
                            64'(got_result.flushes));
                check_field("fences", 64'(want_result.fences),
                            64'(got_result.fences));
            end
        end
    end

    // bound the run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int unsigned    sent;
        int unsigned    phase_len;
        logic           op;
        slwa_pkg::key_t key;
        leaf_result_t   none;

        none           = '0;
        leaf_fill      = 0;
        writes_total   = '0;
        flushes_total  = '0;
        fences_total   = '0;
        log_mode       = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        gaps_on        = 1'b1;

        // empty leaf, plain mode
        add_probe(slwa_pkg::OP_SEARCH, 64'h0, 1'b0, 1'b0, 1'b1,
                  make_result(1'b0, 1'b0, 0, 48'd0, 48'd0, 48'd0));
        add_probe(slwa_pkg::OP_INSERT, 64'h0, 1'b0, 1'b0, 1'b1,
                  make_result(1'b0, 1'b1, 1, 48'd1, 48'd0, 48'd0));
        add_probe(slwa_pkg::OP_INSERT, '1, 1'b0, 1'b0, 1'b1,
                  make_result(1'b0, 1'b1, 2, 48'd2, 48'd0, 48'd0));
        add_probe(slwa_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, none);
        // equal key goes in front of its twin and shifts everything
        add_probe(slwa_pkg::OP_INSERT, 64'h0, 1'b0, 1'b0, 1'b0, none);
        add_probe(slwa_pkg::OP_SEARCH, '1, 1'b0, 1'b0, 1'b0, none);
        add_probe(slwa_pkg::OP_SEARCH, 64'h1, 1'b0, 1'b0, 1'b0, none);
        add_probe(slwa_pkg::OP_SEARCH, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, none);
        add_probe(slwa_pkg::OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0, 1'b0, none);
        // logged inserts
        add_probe(slwa_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 1'b1, 1'b1, 1'b0, none);
        add_probe(slwa_pkg::OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0, none);
        add_probe(slwa_pkg::OP_INSERT, '1, 1'b0, 1'b0, 1'b0, none);
        add_probe(slwa_pkg::OP_SEARCH, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0, none);
        add_probe(slwa_pkg::OP_SEARCH, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0, none);
        // back to plain mode
        add_probe(slwa_pkg::OP_INSERT, 64'h1, 1'b1, 1'b0, 1'b0, none);
        add_probe(slwa_pkg::OP_SEARCH, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, none);
        add_probe(slwa_pkg::OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, none);
        add_probe(slwa_pkg::OP_SEARCH, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, none);

        // reset
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (probe_rows[i]) begin
            if (probe_rows[i].set_log) begin
                drain_results();
                write_log(probe_rows[i].log_val);
            end
            send_item(probe_rows[i].op, probe_rows[i].key, probe_rows[i].has_want,
                      probe_rows[i].want);
        end

        // random phases, each behind a mode write at idle
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_results();
            write_log(1'($urandom_range(1)));
            phase_len = $urandom_range(10, 60);
            if (phase_len > RANDOM_ITEMS - sent) begin
                phase_len = RANDOM_ITEMS - sent;
            end
            repeat (phase_len) begin
                gaps_on = !(sent >= 300 && sent < 500);
                op  = ($urandom_range(99) < 8) ? slwa_pkg::OP_INSERT : slwa_pkg::OP_SEARCH;
                key = (op == slwa_pkg::OP_INSERT) ? pick_insert_key() : pick_search_key();
                send_item(op, key, 1'b0, none);
                sent++;
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
